@@ sv/pica_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pica_pkg;

    // sizing
    localparam int CHANNELS  = 8;
    localparam int PIN_COUNT = 32;
    localparam int PIN_W     = 5;
    localparam int FLAG_W    = 8;
    localparam int CH_W      = 3;
    localparam int CH_IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W     = $clog2(CHANNELS + 1);
    localparam int FLAG_EXT  = (CHANNELS > FLAG_W) ? CHANNELS : FLAG_W;

    typedef enum logic [1:0] {
        ACT_ENABLE,
        ACT_DISABLE,
        ACT_CLEAR,
        ACT_EVENT
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_MAPPED,
        ST_FULL,
        ST_NOT_FOUND
    } t_status;

    typedef enum logic [1:0] {
        TOP_NONE,
        TOP_ALLOC,
        TOP_FREE,
        TOP_CLEAR
    } t_tbl_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_RES,
        S_EVT
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [PIN_W-1:0]   pin;
        logic [FLAG_W-1:0]  event_flags;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [CH_W-1:0]    channel;
        logic [PIN_W-1:0]   pin_out;
        logic               irq_enabled;
        logic               last;
    } t_out;

    // table update from the sequencer
    typedef struct packed {
        t_tbl_op            op;
        logic [CH_IW-1:0]   idx;
        logic [PIN_W-1:0]   pin;
    } t_tbl_cmd;

    // table view seen by the sequencer
    typedef struct packed {
        logic [CHANNELS-1:0] used;
        logic                rd_used;
        logic [PIN_W-1:0]    rd_pin;
        logic                line;
        logic                full;
    } t_tbl_stat;

endpackage

`default_nettype wire

@@ sv/pica_tbl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pica_tbl
    import pica_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CH_IW-1:0] i_rd_idx,
    input  wire t_tbl_cmd         i_cmd,
    output t_tbl_stat             o_stat
);

    logic [CHANNELS-1:0] r_used;
    logic [PIN_W-1:0]    r_pin [CHANNELS];
    logic [CNT_W-1:0]    r_count;
    logic                r_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
            r_line  <= 1'b0;
        end else begin
            case (i_cmd.op)
                TOP_ALLOC: begin
                    r_used[i_cmd.idx] <= 1'b1;
                    r_count           <= r_count + CNT_W'(1);
                    r_line            <= 1'b1;
                end
                TOP_FREE: begin
                    r_used[i_cmd.idx] <= 1'b0;
                    if (r_count != '0) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                    // line drops once the last channel goes
                    if (r_count <= CNT_W'(1)) begin
                        r_line <= 1'b0;
                    end
                end
                TOP_CLEAR: begin
                    r_used  <= '0;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // pin of a free channel is never looked at
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == TOP_ALLOC) begin
            r_pin[i_cmd.idx] <= i_cmd.pin;
        end
    end

    always_comb begin
        o_stat.used    = r_used;
        o_stat.rd_used = r_used[i_rd_idx];
        o_stat.rd_pin  = r_pin[i_rd_idx];
        o_stat.line    = r_line;
        o_stat.full    = (r_count >= CNT_W'(CHANNELS));
    end

endmodule

`default_nettype wire

@@ sv/pica_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pica_ctrl
    import pica_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in              i_in,
    input  wire t_tbl_stat        i_stat,
    output t_tbl_cmd              o_cmd,
    output logic [CH_IW-1:0]      o_rd_idx,
    output logic                  o_push_valid,
    output t_out                  o_push_data,
    input  wire logic             i_can_take
);

    localparam logic [CH_IW-1:0] LAST_IDX = CH_IW'(CHANNELS - 1);

    t_state              r_state;
    t_state              n_state;
    t_action             r_act;
    logic [PIN_W-1:0]    r_pin;
    logic [CH_IW-1:0]    r_idx;
    logic [CHANNELS-1:0] r_hits;
    logic                r_found;
    logic [CH_IW-1:0]    r_found_idx;
    logic                r_free;
    logic [CH_IW-1:0]    r_free_idx;
    t_status             r_res_status;
    logic [CH_IW-1:0]    r_res_ch;
    logic [PIN_W-1:0]    r_res_pin;

    logic                accept;
    logic                pin_bad;
    logic [FLAG_EXT-1:0] flags_ext;
    logic [CHANNELS-1:0] hits_in;
    logic                hit;
    logic                scan_end;
    logic                evt_last;
    logic                evt_adv;
    t_tbl_op             apply_op;
    t_status             apply_status;
    logic [CH_IW-1:0]    apply_ch;

    assign accept    = i_in_valid && !o_in_stall;
    assign pin_bad   = (32'(i_in.pin) >= PIN_COUNT);
    assign flags_ext = FLAG_EXT'(i_in.event_flags);
    assign hits_in   = i_stat.used & flags_ext[CHANNELS-1:0];
    assign hit       = i_stat.rd_used && (i_stat.rd_pin == r_pin);
    assign scan_end  = hit || (r_idx == LAST_IDX);
    assign evt_last  = ((r_hits >> 1) == '0);
    assign evt_adv   = !r_hits[0] || i_can_take;

    // outcome of a finished scan
    always_comb begin
        apply_op     = TOP_NONE;
        apply_status = ST_NOT_FOUND;
        apply_ch     = '0;
        if (r_act == ACT_ENABLE) begin
            if (r_found) begin
                apply_status = ST_MAPPED;
                apply_ch     = r_found_idx;
            end else if (r_free && !i_stat.full) begin
                apply_op     = TOP_ALLOC;
                apply_status = ST_DONE;
                apply_ch     = r_free_idx;
            end else begin
                apply_status = ST_FULL;
            end
        end else if (r_found) begin
            apply_op     = TOP_FREE;
            apply_status = ST_DONE;
            apply_ch     = r_found_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.action)
                        ACT_CLEAR: n_state = S_RES;
                        ACT_EVENT: n_state = (i_stat.line && hits_in != '0) ? S_EVT : S_IDLE;
                        default:   n_state = pin_bad ? S_RES : S_SCAN;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: n_state = S_RES;
            S_RES: begin
                if (i_can_take) begin
                    n_state = S_IDLE;
                end
            end
            S_EVT: begin
                if (evt_adv && evt_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        o_rd_idx     = r_idx;
        o_cmd.op     = TOP_NONE;
        o_cmd.idx    = apply_ch;
        o_cmd.pin    = r_pin;
        o_push_valid = 1'b0;
        o_push_data  = '{status: r_res_status, channel: CH_W'(r_res_ch), pin_out: r_res_pin,
                         irq_enabled: i_stat.line, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (accept && i_in.action == ACT_CLEAR) begin
                    o_cmd.op = TOP_CLEAR;
                end
            end
            S_APPLY: o_cmd.op = apply_op;
            S_RES:   o_push_valid = 1'b1;
            S_EVT: begin
                o_push_valid = r_hits[0];
                o_push_data  = '{status: ST_DONE, channel: CH_W'(r_idx),
                                 pin_out: i_stat.rd_pin, irq_enabled: i_stat.line,
                                 last: evt_last};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_act        <= i_in.action;
                    r_pin        <= i_in.pin;
                    r_idx        <= '0;
                    r_found      <= 1'b0;
                    r_free       <= 1'b0;
                    r_hits       <= hits_in;
                    r_res_ch     <= '0;
                    r_res_status <= (i_in.action == ACT_CLEAR) ? ST_DONE : ST_NOT_FOUND;
                    r_res_pin    <= (i_in.action == ACT_CLEAR) ? '0 : i_in.pin;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    r_found     <= 1'b1;
                    r_found_idx <= r_idx;
                end
                // remember the lowest free channel on the way
                if (!i_stat.rd_used && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_idx;
                end
                r_idx <= r_idx + CH_IW'(1);
            end
            S_APPLY: begin
                r_res_status <= apply_status;
                r_res_ch     <= apply_ch;
            end
            S_EVT: begin
                if (evt_adv) begin
                    r_hits <= r_hits >> 1;
                    r_idx  <= r_idx + CH_IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    a_clear_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.action == ACT_CLEAR) |=> (r_state == S_RES))
        else $error("clear request did not go straight to its result");

    a_evt_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVT && o_push_valid) |-> i_stat.rd_used)
        else $error("event result for an unmapped channel");

    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == TOP_ALLOC) |-> !i_stat.used[o_cmd.idx])
        else $error("allocation into a channel already in use");

    a_res_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES && !i_can_take) |=> (r_state == S_RES && $stable(r_res_status)))
        else $error("pending result lost while output is busy");

endmodule

`default_nettype wire

@@ sv/pin_interrupt_channel_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake                | payload
// in      | request   | i_in_valid / o_in_stall   | i_in  (t_in: action, pin, event_flags)
// out     | result    | o_out_valid / i_out_stall | o_out (t_out: status, channel, pin_out,
//         |           |                           |        irq_enabled, last)
//
// one request at a time; the sequencer scans the channel table one entry per cycle
// enable / disable: scan of k channels (1 to CHANNELS, stops on a match), then apply, then result
// clear: straight to the result; event: walks the channels from 0 up to the highest flagged mapped one
// reset clears the used bits, the count and the interrupt line at once, no clearing pass
// a stalled output register holds the sequencer; results are never dropped

module pin_interrupt_channel_allocator
    import pica_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    t_tbl_cmd         cmd;
    t_tbl_stat        stat;
    logic [CH_IW-1:0] rd_idx;
    logic             push_valid;
    t_out             push_data;
    logic             can_take;

    logic             r_out_valid;
    t_out             r_out;

    // output register frees up when empty or being taken this cycle
    assign can_take = !r_out_valid || !i_out_stall;

    // sequencer: accepts the request, walks the table, builds results
    pica_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_rd_idx     (rd_idx),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_can_take   (can_take)
    );

    // channel table: used bits, pins, used count, interrupt line
    pica_tbl u_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .i_cmd    (cmd),
        .o_stat   (stat)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_take) begin
            r_out_valid <= push_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_take && push_valid) begin
            r_out <= push_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
